// File: rtl/core/hslrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Fixed-point formats, pixel and color payload types, and the small helpers
// used by the converter pipeline.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FIELD_W       = FRACTION_BITS + 1;
  localparam int HUE6_W        = FIELD_W + 3;
  localparam int LEVEL_W       = 2 * FRACTION_BITS + 1;
  localparam int SCALED_W      = LEVEL_W + 8;
  localparam int CHANNEL_W     = 8;

  localparam logic [FIELD_W-1:0] ONE   = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FIELD_W-1:0] HALF  = ONE >> 1;
  localparam logic [FIELD_W-1:0] THIRD = FIELD_W'((1 << FRACTION_BITS) / 3);

  localparam logic [HUE6_W-1:0] ONE_X4  = HUE6_W'(ONE) << 2;
  localparam logic [HUE6_W-1:0] ONE_X1  = HUE6_W'(ONE);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1) << (2 * FRACTION_BITS);

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] lightness;
  } hslrgb_pixel_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] red;
    logic [CHANNEL_W-1:0] green;
    logic [CHANNEL_W-1:0] blue;
  } hslrgb_color_t;

  // Saturate a field to 1.0.
  function automatic logic [FIELD_W-1:0] clamp_unit(input logic [FIELD_W-1:0] x);
    return (x > ONE) ? ONE : x;
  endfunction

  // Hue plus a third, wrapped once into 0..1.
  function automatic logic [FIELD_W-1:0] hue_plus_third(input logic [FIELD_W-1:0] h);
    logic [FIELD_W:0] s;
    s = {1'b0, h} + {1'b0, THIRD};
    if (s > {1'b0, ONE}) begin
      s = s - {1'b0, ONE};
    end
    return s[FIELD_W-1:0];
  endfunction

  // Hue minus a third, wrapped once into 0..1.
  function automatic logic [FIELD_W-1:0] hue_minus_third(input logic [FIELD_W-1:0] h);
    logic [FIELD_W-1:0] r;
    if (h < THIRD) begin
      r = h + (ONE - THIRD);
    end else begin
      r = h - THIRD;
    end
    return r;
  endfunction

  // Weight of (v2 - v1) on the hue ramp, with FRACTION_BITS fractional bits.
  function automatic logic [FIELD_W-1:0] ramp_weight(input logic [FIELD_W-1:0] h);
    logic [HUE6_W-1:0] h6;
    logic [HUE6_W-1:0] fall;
    logic [FIELD_W-1:0] w;
    h6   = (HUE6_W'(h) << 2) + (HUE6_W'(h) << 1);
    fall = ONE_X4 - h6;
    priority if (h6 < ONE_X1) begin
      w = h6[FIELD_W-1:0];
    end else if (h < HALF) begin
      w = ONE;
    end else if (h6 < ONE_X4) begin
      w = fall[FIELD_W-1:0];
    end else begin
      w = '0;
    end
    return w;
  endfunction

  // Level times 255, drop the fraction, saturate to a byte.
  function automatic logic [CHANNEL_W-1:0] scale_channel(input logic [LEVEL_W-1:0] level);
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-LEVEL_W:0] whole;
    scaled = (SCALED_W'(level) << 8) - SCALED_W'(level);
    whole  = scaled[SCALED_W-1:2*FRACTION_BITS];
    return (whole > (SCALED_W-LEVEL_W+1)'(255)) ? 8'hFF : whole[CHANNEL_W-1:0];
  endfunction

endpackage

// File: rtl/core/hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter unit
// Five-stage pipeline turning fixed-point hue, saturation and lightness into
// 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock when the output side keeps up and returns
// its color through stages 1 to 4 and the output register; each stage holds its own
// valid bit and advances whenever the stage after it is empty or moving, so
// bubbles close up and a stalled output backs the requests up one stage at a
// time. The stage cut is set by the multipliers: lightness times saturation in
// stage 1 and the three ramp products in stage 3, each 17 by 17 bits and fully
// pipelined.
// Zero saturation needs no path of its own: both levels then equal the
// lightness and every channel comes out as lightness times 255.
module hsl_to_rgb_converter_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  hslrgb_pkg::hslrgb_pixel_t pixel,
  output logic                  color_valid,
  input  logic                  color_ready,
  output hslrgb_pkg::hslrgb_color_t color
);
  import hslrgb_pkg::*;

  // Stage 1: clamped inputs, product, wrapped hues
  logic                 s1_valid;
  logic [FIELD_W-1:0]   s1_light;
  logic [FIELD_W-1:0]   s1_sat;
  logic [FIELD_W-1:0]   s1_prod;
  logic [FIELD_W-1:0]   s1_hue_r;
  logic [FIELD_W-1:0]   s1_hue_g;
  logic [FIELD_W-1:0]   s1_hue_b;
  // Stage 2: low level, level spread, ramp weights
  logic                 s2_valid;
  logic [FIELD_W-1:0]   s2_low;
  logic [FIELD_W-1:0]   s2_diff;
  logic [FIELD_W-1:0]   s2_w_r;
  logic [FIELD_W-1:0]   s2_w_g;
  logic [FIELD_W-1:0]   s2_w_b;
  // Stage 3: ramp products
  logic                 s3_valid;
  logic [FIELD_W-1:0]   s3_low;
  logic [LEVEL_W-1:0]   s3_prod_r;
  logic [LEVEL_W-1:0]   s3_prod_g;
  logic [LEVEL_W-1:0]   s3_prod_b;
  // Stage 4: levels
  logic                 s4_valid;
  logic [LEVEL_W-1:0]   s4_level_r;
  logic [LEVEL_W-1:0]   s4_level_g;
  logic [LEVEL_W-1:0]   s4_level_b;

  logic s2_ready, s3_ready, s4_ready, s5_ready;

  logic [FIELD_W-1:0]   in_hue, in_sat, in_light;
  logic [2*FIELD_W-1:0] ls_full;
  logic [FIELD_W:0]     high_sum;
  logic [FIELD_W:0]     low_sum;

  assign s5_ready    = !color_valid || color_ready;
  assign s4_ready    = !s4_valid || s5_ready;
  assign s3_ready    = !s3_valid || s4_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign pixel_ready = !s1_valid || s2_ready;

  always_comb begin
    in_hue   = clamp_unit(pixel.hue);
    in_sat   = clamp_unit(pixel.saturation);
    in_light = clamp_unit(pixel.lightness);
    ls_full  = in_light * in_sat;
  end

  // High level: L + L*S below half lightness, else L + S - L*S.
  always_comb begin
    if (s1_light < HALF) begin
      high_sum = {1'b0, s1_light} + {1'b0, s1_prod};
    end else begin
      high_sum = {1'b0, s1_light} + {1'b0, s1_sat} - {1'b0, s1_prod};
    end
    low_sum = ({1'b0, s1_light} << 1) - high_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      color_valid <= 1'b0;
    end else begin
      if (pixel_ready) begin
        s1_valid <= pixel_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
      if (s5_ready) begin
        color_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      s1_light <= in_light;
      s1_sat   <= in_sat;
      s1_prod  <= ls_full[2*FRACTION_BITS:FRACTION_BITS];
      s1_hue_r <= hue_plus_third(in_hue);
      s1_hue_g <= in_hue;
      s1_hue_b <= hue_minus_third(in_hue);
    end
    if (s2_ready && s1_valid) begin
      s2_low  <= low_sum[FIELD_W-1:0];
      s2_diff <= high_sum[FIELD_W-1:0] - low_sum[FIELD_W-1:0];
      s2_w_r  <= ramp_weight(s1_hue_r);
      s2_w_g  <= ramp_weight(s1_hue_g);
      s2_w_b  <= ramp_weight(s1_hue_b);
    end
    if (s3_ready && s2_valid) begin
      s3_low    <= s2_low;
      s3_prod_r <= LEVEL_W'(s2_diff * s2_w_r);
      s3_prod_g <= LEVEL_W'(s2_diff * s2_w_g);
      s3_prod_b <= LEVEL_W'(s2_diff * s2_w_b);
    end
    if (s4_ready && s3_valid) begin
      s4_level_r <= (LEVEL_W'(s3_low) << FRACTION_BITS) + s3_prod_r;
      s4_level_g <= (LEVEL_W'(s3_low) << FRACTION_BITS) + s3_prod_g;
      s4_level_b <= (LEVEL_W'(s3_low) << FRACTION_BITS) + s3_prod_b;
    end
    if (s5_ready && s4_valid) begin
      color.red   <= scale_channel(s4_level_r);
      color.green <= scale_channel(s4_level_g);
      color.blue  <= scale_channel(s4_level_b);
    end
  end

  // The input side may only block when every stage is full and the output is held.
  assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (s1_valid && s2_valid && s3_valid && s4_valid && color_valid
                      && !color_ready))
    else $error("input blocked with room in the pipeline");

  // The low level never goes negative and never exceeds the high level.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (!low_sum[FIELD_W] && !high_sum[FIELD_W] && (high_sum >= low_sum)))
    else $error("level ordering broken");

  // A level never exceeds 1.0 squared, so scaling cannot overflow a byte.
  assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_level_r <= LEVEL_MAX && s4_level_g <= LEVEL_MAX
                  && s4_level_b <= LEVEL_MAX))
    else $error("channel level above full scale");

endmodule

// File: verif/tb_hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter unit testbench
// Streams pixels through the converter over valid/ready on both sides and
// checks every color against an in-order queue of predicted colors. A short
// table of corner pixels runs first, then random pixels with random idling
// on both sides, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter_unit;
  import hslrgb_pkg::*;

  localparam longint UNIT_L  = longint'(1) << FRACTION_BITS;
  localparam longint THIRD_L = UNIT_L / 3;
  localparam int RANDOM_PIXELS = 550;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 80;

  typedef struct packed {
    hslrgb_pixel_t px;
    logic          typed;
    hslrgb_color_t want;
  } stim_row_t;

  logic          clk;
  logic          rst;
  logic          pixel_valid;
  logic          pixel_ready;
  hslrgb_pixel_t pixel;
  logic          color_valid;
  logic          color_ready;
  hslrgb_color_t color;

  hslrgb_color_t expected_colors[$];
  hslrgb_color_t oldest_color;
  stim_row_t     directed_rows[$];
  logic          typed_check;
  hslrgb_color_t typed_color;
  bit            calm_phase;
  bit            hold_off_req;
  int            error_count;

  hsl_to_rgb_converter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .color       (color)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint clamp_fraction(input logic [FIELD_W-1:0] x);
    return (longint'(x) > UNIT_L) ? UNIT_L : longint'(x);
  endfunction

  // Evaluate the hue ramp between the low and high levels, scale to a byte.
  function automatic logic [7:0] ramp_byte(input longint lo, input longint hi,
                                           input longint hh);
    longint level;
    longint scaled;
    if (hh < 0) hh = hh + UNIT_L;
    if (hh > UNIT_L) hh = hh - UNIT_L;
    if (6 * hh < UNIT_L) begin
      level = lo * UNIT_L + (hi - lo) * 6 * hh;
    end else if (2 * hh < UNIT_L) begin
      level = hi * UNIT_L;
    end else if (3 * hh < 2 * UNIT_L) begin
      level = lo * UNIT_L + (hi - lo) * (4 * UNIT_L - 6 * hh);
    end else begin
      level = lo * UNIT_L;
    end
    if (level < 0) return 8'd0;
    scaled = (level * 255) >>> (2 * FRACTION_BITS);
    return (scaled > 255) ? 8'hFF : scaled[7:0];
  endfunction

  function automatic hslrgb_color_t predict_color(input hslrgb_pixel_t px);
    longint h;
    longint s;
    longint l;
    longint hi;
    longint lo;
    longint grey;
    hslrgb_color_t c;
    h = clamp_fraction(px.hue);
    s = clamp_fraction(px.saturation);
    l = clamp_fraction(px.lightness);
    if (s == 0) begin
      grey = (l * 255) >>> FRACTION_BITS;
      if (grey > 255) grey = 255;
      c.red   = grey[7:0];
      c.green = grey[7:0];
      c.blue  = grey[7:0];
    end else begin
      if (2 * l < UNIT_L) begin
        hi = (l * (UNIT_L + s)) >>> FRACTION_BITS;
      end else begin
        hi = l + s - ((s * l) >>> FRACTION_BITS);
      end
      lo = 2 * l - hi;
      c.red   = ramp_byte(lo, hi, h + THIRD_L);
      c.green = ramp_byte(lo, hi, h);
      c.blue  = ramp_byte(lo, hi, h - THIRD_L);
    end
    return c;
  endfunction

  function automatic stim_row_t stim_row(input int h, input int s, input int l,
                                         input bit typed, input int r,
                                         input int g, input int b);
    stim_row_t row;
    row.px    = hslrgb_pixel_t'({FIELD_W'(h), FIELD_W'(s), FIELD_W'(l)});
    row.typed = typed;
    row.want  = hslrgb_color_t'({8'(r), 8'(g), 8'(b)});
    return row;
  endfunction

  // Mostly in-range fractions, with the ends and out-of-range codes mixed in.
  function automatic logic [FIELD_W-1:0] pick_fraction();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ONE;
      2: v = FIELD_W'($urandom_range(32'(ONE) + 1, 32'h1FFFF));
      3: v = FIELD_W'($urandom_range(0, 255));
      default: v = FIELD_W'($urandom_range(0, 32'(ONE)));
    endcase
    return v;
  endfunction

  // Hue lands near the ramp corners and wrap points fairly often.
  function automatic logic [FIELD_W-1:0] pick_hue();
    int e;
    if ($urandom_range(0, 3) != 0) return pick_fraction();
    case ($urandom_range(0, 6))
      0: e = 10922;
      1: e = 21845;
      2: e = 32768;
      3: e = 43690;
      4: e = 54613;
      5: e = 65536;
      default: e = 2;
    endcase
    e = e + int'($urandom_range(0, 4)) - 2;
    return FIELD_W'(e);
  endfunction

  task automatic offer_pixel(input hslrgb_pixel_t px, input logic typed,
                             input hslrgb_color_t want);
    @(negedge clk);
    while (!calm_phase && $urandom_range(0, 99) < 9) begin
      pixel_valid = 1'b0;
      @(negedge clk);
    end
    pixel       = px;
    typed_check = typed;
    typed_color = want;
    pixel_valid = 1'b1;
    do @(posedge clk); while (!pixel_ready);
  endtask

  // Scoreboard: check the result first, then log the new request.
  always @(posedge clk) begin
    if (!rst) begin
      if (color_valid && color_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time,
                   color.red, color.green, color.blue);
          error_count++;
        end else begin
          oldest_color = expected_colors.pop_front();
          if (color.red !== oldest_color.red) begin
            $display("%0t: red expected %0d actual %0d", $time,
                     oldest_color.red, color.red);
            error_count++;
          end
          if (color.green !== oldest_color.green) begin
            $display("%0t: green expected %0d actual %0d", $time,
                     oldest_color.green, color.green);
            error_count++;
          end
          if (color.blue !== oldest_color.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time,
                     oldest_color.blue, color.blue);
            error_count++;
          end
        end
      end
      if (pixel_valid && pixel_ready)
        expected_colors.push_back(typed_check ? typed_color : predict_color(pixel));
    end
  end

  // Output side: random back-pressure, plus one long hold on request.
  initial begin
    color_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        color_ready  = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        color_ready = calm_phase || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin
    hslrgb_pixel_t px;
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    typed_check  = 1'b0;
    typed_color  = '0;
    calm_phase   = 1'b0;
    hold_off_req = 1'b0;
    error_count  = 0;

    // hue, saturation, lightness; typed rows carry red, green, blue
    directed_rows.push_back(stim_row(0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(stim_row(0, 0, 65536, 1, 255, 255, 255));
    directed_rows.push_back(stim_row('h1FFFF, 0, 'h1FFFF, 1, 255, 255, 255));
    directed_rows.push_back(stim_row('h12345, 0, 32768, 1, 127, 127, 127));
    directed_rows.push_back(stim_row(0, 65536, 32768, 1, 255, 0, 0));
    directed_rows.push_back(stim_row('h0AAAA, 65536, 0, 1, 0, 0, 0));
    directed_rows.push_back(stim_row('h15555, 65536, 65536, 1, 255, 255, 255));
    directed_rows.push_back(stim_row(65536, 65536, 32768, 0, 0, 0, 0));
    directed_rows.push_back(stim_row('h1FFFF, 65536, 32768, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(21845, 65536, 32768, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(21844, 65536, 32768, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(10922, 'h1FFFF, 'h4000, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(10923, 65536, 'h4000, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(32767, 'h8000, 'hC000, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(32768, 'h8000, 'hC000, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(43690, 'hFFFF, 'h7FFF, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(43691, 65536, 'h8001, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(54613, 1, 32768, 0, 0, 0, 0));
    directed_rows.push_back(stim_row('h15555, 'h0AAAA, 'h15555, 0, 0, 0, 0));
    directed_rows.push_back(stim_row('h0AAAA, 'h15555, 'h0AAAA, 0, 0, 0, 0));
    directed_rows.push_back(stim_row('h1FFFF, 'h1FFFF, 'h1FFFF, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(1, 1, 1, 0, 0, 0, 0));
    directed_rows.push_back(stim_row('hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0));
    directed_rows.push_back(stim_row(0, 65536, 'h1FFFF, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      offer_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);

    // hold new requests until the table has fully drained
    @(negedge clk);
    pixel_valid = 1'b0;
    wait (expected_colors.size() == 0);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      calm_phase = (n >= 150 && n < 280);
      if (n == 350) hold_off_req = 1'b1;
      px.hue        = pick_hue();
      px.saturation = ($urandom_range(0, 7) == 0) ? '0 : pick_fraction();
      px.lightness  = pick_fraction();
      offer_pixel(px, 1'b0, '0);
    end

    @(negedge clk);
    pixel_valid = 1'b0;
    wait (expected_colors.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
